>>> rtl/core/bgcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgcd_pkg: shared definitions of the binary gcd unit
// Operand and field widths, stream packing and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package bgcd_pkg;

	// Working width of the operands; bits above it are ignored.
	localparam int OPERAND_WIDTH = 64;
	// Width of the operand and result fields on the streams.
	localparam int FIELD_WIDTH   = 64;
	localparam int COUNT_WIDTH   = 8;
	localparam int TWOS_WIDTH    = $clog2(OPERAND_WIDTH);

	localparam int IN_TDATA_WIDTH  = 2 * FIELD_WIDTH;
	localparam int OUT_TDATA_WIDTH = ((FIELD_WIDTH + COUNT_WIDTH + 7) / 8) * 8;

	localparam logic [COUNT_WIDTH-1:0] STEP_MAX = '1;

	typedef logic [OPERAND_WIDTH-1:0] operand_t;
	typedef logic [COUNT_WIDTH-1:0]   count_t;
	typedef logic [TWOS_WIDTH-1:0]    twos_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;     // take a new request into the working registers
		logic step;     // perform one reduction step
		logic capture;  // move the finished result into the output register
	} bgcd_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic done;     // the smaller working value is zero
	} bgcd_stat_t;

endpackage

>>> rtl/core/bgcd_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgcd_dp: datapath of the binary gcd unit
// Working registers, one reduction step per cycle, the final doubling and
// the result register.
// ----------------------------------------------------------------------------
module bgcd_dp
	import bgcd_pkg::*;
(
	input  logic                   clk,
	input  logic [FIELD_WIDTH-1:0] first_operand,
	input  logic [FIELD_WIDTH-1:0] second_operand,
	input  bgcd_cmd_t              cmd,
	output bgcd_stat_t             stat,
	output logic [FIELD_WIDTH-1:0] gcd_value,
	output count_t                 step_count
);

	operand_t a_q, b_q, gcd_q;
	twos_t    twos_q;
	count_t   steps_q, cnt_q;

	operand_t big, small_v, diff, big_nx, small_nx;
	logic     big_odd, small_odd;

	// Order the working pair so that big >= small.
	always_comb begin
		if (b_q > a_q) begin
			big     = b_q;
			small_v = a_q;
		end else begin
			big     = a_q;
			small_v = b_q;
		end
		big_odd   = big[0];
		small_odd = small_v[0];
		diff      = big - small_v;
		big_nx    = big;
		small_nx  = small_v;
		unique case ({big_odd, small_odd})
			2'b00: begin
				big_nx   = big >> 1;
				small_nx = small_v >> 1;
			end
			2'b01: big_nx   = big >> 1;
			2'b10: small_nx = small_v >> 1;
			2'b11: big_nx   = diff >> 1;
			default: ;
		endcase
	end

	assign stat.done = (small_v == '0);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q     <= first_operand[OPERAND_WIDTH-1:0];
			b_q     <= second_operand[OPERAND_WIDTH-1:0];
			twos_q  <= '0;
			steps_q <= '0;
		end else if (cmd.step) begin
			a_q     <= big_nx;
			b_q     <= small_nx;
			if (!big_odd && !small_odd) begin
				twos_q <= twos_q + 1'b1;
			end
			if (steps_q != STEP_MAX) begin
				steps_q <= steps_q + 1'b1;
			end
		end
		if (cmd.capture) begin
			// The final step counts too.
			gcd_q <= big << twos_q;
			cnt_q <= (steps_q == STEP_MAX) ? steps_q : steps_q + 1'b1;
		end
	end

	assign gcd_value  = FIELD_WIDTH'(gcd_q);
	assign step_count = cnt_q;

endmodule

>>> rtl/core/bgcd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgcd_ctrl: controller of the binary gcd unit
// Sequences load, reduction steps and result capture, and owns the
// handshakes of both streams.
// ----------------------------------------------------------------------------
module bgcd_ctrl
	import bgcd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  bgcd_stat_t stat,
	output bgcd_cmd_t  cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_ready    = (state_q == ST_IDLE);
	assign cmd.load    = in_ready && in_valid;
	assign cmd.step    = (state_q == ST_RUN) && !stat.done;
	assign cmd.capture = (state_q == ST_RUN) && stat.done && (!out_valid_q || out_ready);
	assign out_valid   = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (cmd.capture) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/core/binary_gcd_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_gcd_unit: greatest common divisor by the binary method
// Stream in two unsigned operands, stream out their gcd and step count.
// ----------------------------------------------------------------------------
// One request is processed at a time. A request is taken into the working registers, then
// the datapath performs one reduction step per cycle (order the pair, then
// halve one or both values or replace the larger by half the difference),
// and the final step doubles the answer back by the shared powers of two in
// one barrel shift while it loads the output register. The step_count
// reported with the result counts the reduction steps and that final step,
// saturating at STEP_MAX, and the datapath loop holds a single
// subtract-and-shift step.
// The output register decouples the two streams: a new request is accepted
// while the previous result still waits to be taken, and a finished result
// holds in the datapath until the output register frees up. Operand bits
// above OPERAND_WIDTH are ignored. gcd(0,0) is 0 with a step count of 1.
// ----------------------------------------------------------------------------
module binary_gcd_unit
	import bgcd_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	// Request stream.
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	// Fields from bit 0 up: first_operand (64), second_operand (64).
	input  logic [IN_TDATA_WIDTH-1:0]  s_axis_tdata,
	// Result stream.
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// Fields from bit 0 up: gcd_value (64), step_count (8).
	output logic [OUT_TDATA_WIDTH-1:0] m_axis_tdata
);

	bgcd_cmd_t              cmd;
	bgcd_stat_t             stat;
	logic [FIELD_WIDTH-1:0] gcd_value;
	count_t                 step_count;

	// The controller decides when to load, step and capture; it never
	// looks at the operand values beyond the done flag.
	bgcd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	bgcd_dp u_dp (
		.clk            (clk),
		.first_operand  (s_axis_tdata[FIELD_WIDTH-1:0]),
		.second_operand (s_axis_tdata[2*FIELD_WIDTH-1:FIELD_WIDTH]),
		.cmd            (cmd),
		.stat           (stat),
		.gcd_value      (gcd_value),
		.step_count     (step_count)
	);

	// Pack the result fields; any padding bits above them are zero.
	assign m_axis_tdata = OUT_TDATA_WIDTH'({step_count, gcd_value});

endmodule

>>> rtl/core/bgcd_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgcd_chk: port checker for the binary gcd unit
// Watches the streams of the top level over time.
// ----------------------------------------------------------------------------
module bgcd_chk
	import bgcd_pkg::*;
(
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_axis_tvalid,
	input logic                       s_axis_tready,
	input logic                       m_axis_tvalid,
	input logic                       m_axis_tready,
	input logic [OUT_TDATA_WIDTH-1:0] m_axis_tdata
);

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// Every result counts at least its final step.
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[FIELD_WIDTH+COUNT_WIDTH-1:FIELD_WIDTH] != '0)
		else $error("result with zero step count");

	// After a request is taken the unit is busy with it.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request accepted while busy");

	// A result never appears in the cycle right after its request.
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
		else $error("result appeared too early");

endmodule

bind binary_gcd_unit bgcd_chk u_bgcd_chk (.*);

>>> sim/binary_gcd_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_gcd_unit_tb: self-checking bench for the binary gcd unit
// Pushes directed and random operand pairs through the request stream while
// the result stream stalls on its own pattern. Each accepted request is run
// through a bit-exact model of the binary method, and every returned gcd and
// step count is compared against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module binary_gcd_unit_tb;
	import bgcd_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 600_000;
	localparam int unsigned DRAIN_CYCLES  = 140;
	localparam int unsigned RANDOM_ITEMS  = 950;
	localparam int unsigned PRINT_LIMIT   = 40;

	typedef logic [FIELD_WIDTH-1:0] field_t;

	typedef struct packed {
		field_t first_operand;
		field_t second_operand;
		field_t gcd_value;
		count_t step_count;
	} gcd_expect_t;

	typedef enum logic [1:0] {
		SINK_ALWAYS,
		SINK_COIN,
		SINK_MOSTLY_STALLED,
		SINK_MOSTLY_READY
	} sink_mode_e;

	typedef enum logic [2:0] {
		PAIR_FULL_RANDOM,
		PAIR_COMMON_FACTOR,
		PAIR_SHARED_TWOS,
		PAIR_RANDOM_LENGTHS,
		PAIR_CORNER
	} pair_kind_e;

	// Holds the predicted results of accepted requests, oldest first.
	class gcd_expectations;
		gcd_expect_t pending_results[$];
		int unsigned errors;

		// Stein's method with the step count, at the unit's operand width.
		static function gcd_expect_t gcd_of(field_t x, field_t y);
			gcd_expect_t r;
			operand_t a, b, t;
			int unsigned twos, steps;
			a = x[OPERAND_WIDTH-1:0];
			b = y[OPERAND_WIDTH-1:0];
			twos = 0;
			steps = 0;
			while (1'b1) begin
				if (steps < STEP_MAX)
					steps++;
				if (b > a) begin
					t = a;
					a = b;
					b = t;
				end
				if (b == '0)
					break;
				if (!a[0] && !b[0]) begin
					a = a >> 1;
					b = b >> 1;
					twos++;
				end else if (!a[0]) begin
					a = a >> 1;
				end else if (!b[0]) begin
					b = b >> 1;
				end else begin
					a = (a - b) >> 1;
				end
			end
			if (a != '0)
				a = a << twos;
			r.first_operand  = x;
			r.second_operand = y;
			r.gcd_value      = field_t'(a);
			r.step_count     = count_t'(steps);
			return r;
		endfunction

		function void note_request(field_t x, field_t y);
			pending_results.push_back(gcd_of(x, y));
		endfunction

		function int unsigned outstanding();
			return pending_results.size();
		endfunction

		task report_mismatch(string what, field_t got, field_t want, gcd_expect_t e);
			if (errors < PRINT_LIMIT)
				$display("%0t mismatch in %s: got %0d, expected %0d (operands %0d, %0d)",
					$time, what, got, want, e.first_operand, e.second_operand);
			errors++;
		endtask

		task check_result(logic [OUT_TDATA_WIDTH-1:0] data);
			gcd_expect_t e;
			field_t got_gcd;
			count_t got_steps;
			got_gcd   = data[FIELD_WIDTH-1:0];
			got_steps = data[FIELD_WIDTH +: COUNT_WIDTH];
			if (pending_results.size() == 0) begin
				e = '0;
				report_mismatch("unexpected result", got_gcd, '0, e);
			end else begin
				e = pending_results.pop_front();
				if (got_gcd !== e.gcd_value)
					report_mismatch("gcd_value", got_gcd, e.gcd_value, e);
				if (got_steps !== e.step_count)
					report_mismatch("step_count", field_t'(got_steps),
						field_t'(e.step_count), e);
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [IN_TDATA_WIDTH-1:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [OUT_TDATA_WIDTH-1:0] m_axis_tdata;

	gcd_expectations ledger;
	int unsigned burst_left;
	int unsigned cycle_count;
	int unsigned sink_stretch;
	sink_mode_e sink_mode;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	binary_gcd_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// Low n bits random, the rest zero.
	function automatic field_t random_bits(int unsigned n);
		field_t v;
		v = {$urandom, $urandom};
		if (n < FIELD_WIDTH)
			v &= (field_t'(1) << n) - field_t'(1);
		return v;
	endfunction

	// Sends one request, opening a new burst after a random gap when the
	// current one is used up. Valid stays high between requests of a burst.
	task automatic push_operands(input field_t x, input field_t y);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
			                                         : $urandom_range(1, 8);
			gap = $urandom_range(1, 20);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {y, x};
		do @(posedge clk); while (!s_axis_tready);
		ledger.note_request(x, y);
	endtask

	task automatic push_random_pair();
		pair_kind_e kind;
		field_t x, y, g;
		int unsigned k;
		case ($urandom_range(0, 9))
			0, 1, 2: kind = PAIR_FULL_RANDOM;
			3, 4:    kind = PAIR_COMMON_FACTOR;
			5, 6:    kind = PAIR_SHARED_TWOS;
			7, 8:    kind = PAIR_RANDOM_LENGTHS;
			default: kind = PAIR_CORNER;
		endcase
		case (kind)
			PAIR_FULL_RANDOM: begin
				x = random_bits(FIELD_WIDTH);
				y = random_bits(FIELD_WIDTH);
			end
			PAIR_COMMON_FACTOR: begin
				// A shared odd factor so that the answer is seldom just one.
				g = random_bits($urandom_range(1, 20)) | field_t'(1);
				x = g * random_bits($urandom_range(0, 40));
				y = g * random_bits($urandom_range(0, 40));
			end
			PAIR_SHARED_TWOS: begin
				k = $urandom_range(0, FIELD_WIDTH - 1);
				x = random_bits(FIELD_WIDTH) << k;
				y = random_bits(FIELD_WIDTH) << k;
			end
			PAIR_RANDOM_LENGTHS: begin
				x = random_bits($urandom_range(0, FIELD_WIDTH));
				y = random_bits($urandom_range(0, FIELD_WIDTH));
			end
			default: begin
				x = ($urandom_range(0, 1) == 0) ? '0 : '1;
				case ($urandom_range(0, 3))
					0: y = x;
					1: y = random_bits(FIELD_WIDTH);
					2: y = field_t'(1);
					default: y = '0;
				endcase
				if ($urandom_range(0, 1) == 1) begin
					g = x;
					x = y;
					y = g;
				end
			end
		endcase
		push_operands(x, y);
	endtask

	// Result side: check accepted results, then pick the next ready value
	// from stretches of steady, random, mostly stalled or mostly ready sinking.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				ledger.check_result(m_axis_tdata);
			if (sink_stretch == 0) begin
				sink_mode    = sink_mode_e'($urandom_range(0, 3));
				sink_stretch = $urandom_range(5, 80);
			end
			sink_stretch--;
			case (sink_mode)
				SINK_ALWAYS:         m_axis_tready <= 1'b1;
				SINK_COIN:           m_axis_tready <= 1'($urandom_range(0, 1));
				SINK_MOSTLY_STALLED: m_axis_tready <= ($urandom_range(0, 7) == 0);
				default:             m_axis_tready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		ledger        = new();
		burst_left    = 0;
		cycle_count   = 0;
		sink_stretch  = 0;
		sink_mode     = SINK_ALWAYS;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		m_axis_tready <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero operands, extremes, powers of two and known gcd pairs.
		push_operands('0, '0);
		push_operands('0, field_t'(1));
		push_operands(field_t'(1), '0);
		push_operands('0, '1);
		push_operands('1, '0);
		push_operands('1, '1);
		push_operands(field_t'(1), field_t'(1));
		push_operands('1, field_t'(1));
		push_operands(field_t'(1), '1);
		push_operands(field_t'(1) << 63, field_t'(1) << 63);
		push_operands(field_t'(1) << 63, field_t'(1) << 62);
		push_operands(field_t'(1) << 63, field_t'(1));
		push_operands('1, field_t'(1) << 63);
		push_operands('1, '1 - field_t'(1));
		push_operands(field_t'(12), field_t'(18));
		push_operands(field_t'(48), field_t'(180));
		push_operands(field_t'(17), field_t'(51));
		// Consecutive Fibonacci numbers give a long run of steps.
		push_operands(64'd7540113804746346429, 64'd12200160415121876738);
		push_operands(64'hFFFF_FFFF_FFFF_FFC5, 64'hFFFF_FFFF_FFFF_FFAD);
		push_operands(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
		push_operands(field_t'(3) << 32, field_t'(9) << 32);

		repeat (RANDOM_ITEMS) push_random_pair();
		s_axis_tvalid <= 1'b0;

		while (ledger.outstanding() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (ledger.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
